### hw/rtl/mrtc_pkg.sv
// ----------------------------------------------------------------------------
// Memory range table checker package
// Shared codes, defaults and the stored entry layout for the range table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrtc_pkg;

  // Default number of table entries.
  localparam int TABLE_ENTRIES_DEF = 8;

  // Request opcodes.
  localparam logic [1:0] OP_VALIDATE = 2'd0;
  localparam logic [1:0] OP_SET      = 2'd1;
  localparam logic [1:0] OP_GET      = 2'd2;

  // Memory type codes.
  localparam logic [1:0] TYPE_INVALID = 2'd0;
  localparam logic [1:0] TYPE_RAM     = 2'd1;
  localparam logic [1:0] TYPE_EEPROM  = 2'd2;
  localparam logic [1:0] TYPE_ANY     = 2'd3;

  // Word size and attribute codes that are rejected by set.
  localparam logic [1:0] WSIZE_INVALID = 2'd3;
  localparam logic [1:0] ATTR_INVALID  = 2'd0;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_BAD_RANGE = 3'd3;
  localparam logic [2:0] ST_BAD_WSIZE = 3'd4;
  localparam logic [2:0] ST_BAD_ATTR  = 3'd5;

  // One stored table entry.
  typedef struct packed {
    logic [1:0]  mtype;
    logic [31:0] start;
    logic [31:0] size;
    logic [1:0]  wsize;
    logic [1:0]  attr;
  } mrtc_entry_t;

endpackage

`default_nettype wire

### hw/rtl/memory_range_table_checker.sv
// ----------------------------------------------------------------------------
// Memory range table checker
// Holds a table of memory regions in a synchronous memory and serves set,
// get and validate requests against it, one transaction at a time.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Content
//  in_*     input      in_valid / in_ready   opcode, index, type, range, codes
//  out_*    output     out_valid / out_ready status and stored entry fields
//
//  Set, invalid-type and bad-range validates, out-of-range gets and unused
//  opcodes reach the done state, which loads the result register; a get
//  first passes the get state for its one memory read. A validate that scans
//  issues one memory read per cycle and checks each entry the cycle after its
//  read. The next request is accepted once the result register is loaded.
//  Reset clears the per-entry valid flags at once; no clearing pass is run.
//  A new request is taken while an earlier result waits in the output
//  register; the finished result then holds until that register drains.
//
`timescale 1ns / 1ps
`default_nettype none

module memory_range_table_checker
  import mrtc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_range_index,
  input  wire logic [1:0]  in_mem_type,
  input  wire logic [31:0] in_start_addr,
  input  wire logic [31:0] in_range_size,
  input  wire logic [1:0]  in_word_size,
  input  wire logic [1:0]  in_attributes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [1:0]       out_type_out,
  output logic [31:0]      out_start_out,
  output logic [31:0]      out_size_out,
  output logic [1:0]       out_word_size_out,
  output logic [1:0]       out_attributes_out
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  mrtc_entry_t              mem [TABLE_ENTRIES];
  mrtc_entry_t              rd_data_r;
  logic                     vld_rd_r;
  logic                     rd_pend_r;
  logic                     rd_last_r;
  logic [IDX_W-1:0]         issue_idx_r;
  logic                     issue_done_r;
  logic [1:0]               req_type_r;
  logic [31:0]              req_start_r;
  logic [31:0]              req_last_r;
  logic [2:0]               scan_status_r;
  logic [2:0]               res_status_r;
  mrtc_entry_t              res_entry_r;
  logic                     out_valid_r;
  logic [2:0]               out_status_r;
  mrtc_entry_t              out_entry_r;

  logic                     in_accept;
  logic [IDX_W-1:0]         in_idx;
  logic                     in_idx_ok;
  logic [31:0]              in_last;
  logic [2:0]               set_status;
  logic                     mem_we;
  logic [IDX_W-1:0]         rd_addr;
  mrtc_entry_t              wr_entry;
  logic [31:0]              e_last;
  logic                     start_out;
  logic                     end_out;
  logic                     type_ok;
  logic                     hit;
  logic [2:0]               miss_status;
  logic                     issue_last;
  logic                     scan_issue;
  logic                     out_free;

  // Input decode and set-operand checks.
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_idx    = in_range_index[IDX_W-1:0];
  assign in_idx_ok = (in_range_index < 8'(TABLE_ENTRIES));
  assign in_last   = in_start_addr + in_range_size - 32'd1;

  always_comb begin
    priority if (!in_idx_ok) begin
      set_status = ST_BAD_RANGE;
    end else if (in_mem_type != TYPE_RAM && in_mem_type != TYPE_EEPROM) begin
      set_status = ST_BAD_TYPE;
    end else if (in_word_size == WSIZE_INVALID) begin
      set_status = ST_BAD_WSIZE;
    end else if (in_attributes == ATTR_INVALID) begin
      set_status = ST_BAD_ATTR;
    end else begin
      set_status = ST_OK;
    end
  end

  assign mem_we   = in_accept && (in_opcode == OP_SET) && (set_status == ST_OK);
  assign wr_entry = '{mtype: in_mem_type, start: in_start_addr, size: in_range_size,
                      wsize: in_word_size, attr: in_attributes};

  // Scan evaluation of the entry read in the previous cycle.
  assign e_last      = rd_data_r.start + rd_data_r.size - 32'd1;
  assign start_out   = (req_start_r < rd_data_r.start) || (req_start_r > e_last);
  assign end_out     = (req_last_r > e_last);
  assign type_ok     = (req_type_r == TYPE_ANY) || (req_type_r == rd_data_r.mtype);
  assign hit         = rd_pend_r && vld_rd_r && !start_out && !end_out && type_ok;
  assign miss_status = start_out ? ST_BAD_ADDR : (end_out ? ST_BAD_RANGE : ST_BAD_TYPE);

  assign issue_last = (issue_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign scan_issue = (state_r == S_SCAN) && !issue_done_r && !hit;
  assign rd_addr    = (state_r == S_SCAN) ? issue_idx_r : in_idx;
  assign out_free   = !out_valid_r || out_ready;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_idx] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
    vld_rd_r  <= valid_r[rd_addr];
    rd_last_r <= issue_last;
  end

  // Request sequencer, valid flags and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      rd_pend_r    <= 1'b0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pend_r <= scan_issue;
      // The output register loads a finished result or drains on a handshake.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            req_type_r   <= in_mem_type;
            req_start_r  <= in_start_addr;
            req_last_r   <= in_last;
            res_entry_r  <= '0;
            unique case (in_opcode)
              OP_VALIDATE: begin
                priority if (in_mem_type == TYPE_INVALID) begin
                  res_status_r <= ST_BAD_TYPE;
                  state_r      <= S_DONE;
                end else if (in_last < in_start_addr) begin
                  res_status_r <= ST_BAD_RANGE;
                  state_r      <= S_DONE;
                end else begin
                  scan_status_r <= ST_BAD_ADDR;
                  issue_idx_r   <= '0;
                  issue_done_r  <= 1'b0;
                  state_r       <= S_SCAN;
                end
              end
              OP_SET: begin
                res_status_r <= set_status;
                state_r      <= S_DONE;
                if (mem_we) begin
                  valid_r[in_idx] <= 1'b1;
                end
              end
              OP_GET: begin
                if (!in_idx_ok) begin
                  res_status_r <= ST_BAD_RANGE;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_GET;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                state_r      <= S_DONE;
              end
            endcase
          end
        end
        S_GET: begin
          res_entry_r <= vld_rd_r ? rd_data_r : '0;
          state_r     <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            res_status_r <= ST_OK;
            state_r      <= S_DONE;
          end else begin
            if (rd_pend_r && vld_rd_r) begin
              scan_status_r <= miss_status;
            end
            if (rd_pend_r && rd_last_r) begin
              res_status_r <= vld_rd_r ? miss_status : scan_status_r;
              state_r      <= S_DONE;
            end
            if (!issue_done_r) begin
              issue_idx_r  <= issue_idx_r + IDX_W'(1);
              issue_done_r <= issue_last;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_entry_r  <= res_entry_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_type_out       = out_entry_r.mtype;
  assign out_start_out      = out_entry_r.start;
  assign out_size_out       = out_entry_r.size;
  assign out_word_size_out  = out_entry_r.wsize;
  assign out_attributes_out = out_entry_r.attr;

  // Table writes happen only on an accepted set, never during a scan or get.
  a_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE))
    else $error("table write outside idle state");

  // Every scan read being evaluated was issued from the scan state.
  a_pend_scan : assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == S_SCAN))
    else $error("scan read pending without a scan");

  // A new result is loaded only from the finished-request state.
  a_load_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done state");

  // A failing status never carries entry data.
  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_entry_r == '0))
    else $error("entry data on a failed request");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Memory range table checker testbench
// Drives set, get and validate transactions into the range table checker,
// predicts every status and read-back value from a local copy of the region
// table, and compares each result in order. Both channels idle and stall at
// random, except in one streaming phase where they run at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import mrtc_pkg::*;
();

  localparam int NUM_ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = NUM_ENTRIES + 8;
  localparam int MAX_REPORTS  = 10;

  // Codes that the package does not name.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] WSIZE_BYTE  = 2'd0;
  localparam logic [1:0] WSIZE_WORD  = 2'd1;
  localparam logic [1:0] WSIZE_DWORD = 2'd2;
  localparam logic [1:0] ATTR_READ   = 2'd1;
  localparam logic [1:0] ATTR_WRITE  = 2'd2;
  localparam logic [1:0] ATTR_RW     = 2'd3;

  // One request as it appears on the input channel.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  index;
    logic [1:0]  mtype;
    logic [31:0] start;
    logic [31:0] size;
    logic [1:0]  wsize;
    logic [1:0]  attr;
  } region_req_t;

  // One result: the status and the read-back entry fields.
  typedef struct packed {
    logic [2:0]  status;
    mrtc_entry_t entry;
  } region_result_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode      = '0;
  logic [7:0]  in_range_index = '0;
  logic [1:0]  in_mem_type    = '0;
  logic [31:0] in_start_addr  = '0;
  logic [31:0] in_range_size  = '0;
  logic [1:0]  in_word_size   = '0;
  logic [1:0]  in_attributes  = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_type_out;
  logic [31:0] out_start_out;
  logic [31:0] out_size_out;
  logic [1:0]  out_word_size_out;
  logic [1:0]  out_attributes_out;

  logic           idle_on     = 1'b1;
  int             cycle_count = 0;
  int             fail_count  = 0;
  int             stall_left  = 0;
  mrtc_entry_t    region_table [NUM_ENTRIES];
  region_result_t pending_results [$];

  memory_range_table_checker i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_range_index     (in_range_index),
    .in_mem_type        (in_mem_type),
    .in_start_addr      (in_start_addr),
    .in_range_size      (in_range_size),
    .in_word_size       (in_word_size),
    .in_attributes      (in_attributes),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_type_out       (out_type_out),
    .out_start_out      (out_start_out),
    .out_size_out       (out_size_out),
    .out_word_size_out  (out_word_size_out),
    .out_attributes_out (out_attributes_out)
  );

  // Free-running clock.
  always #5 clk = ~clk;

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("memory_range_table_checker verification failed");
      $finish;
    end
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side back-pressure.
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic region_req_t make_req(input logic [1:0] opcode, input logic [7:0] index,
                                           input logic [1:0] mtype, input logic [31:0] start,
                                           input logic [31:0] size, input logic [1:0] wsize,
                                           input logic [1:0] attr);
    region_req_t req;
    req.opcode = opcode;
    req.index  = index;
    req.mtype  = mtype;
    req.start  = start;
    req.size   = size;
    req.wsize  = wsize;
    req.attr   = attr;
    return req;
  endfunction

  // Range lookup: success on a containing entry of matching type, otherwise
  // the mismatch seen at the last valid entry scanned.
  function automatic logic [2:0] range_lookup_status(input logic [1:0] mtype,
                                                     input logic [31:0] start,
                                                     input logic [31:0] size);
    logic [31:0] last;
    logic [31:0] e_last;
    logic [2:0]  status;
    int          k;
    last   = start + size - 32'd1;
    status = ST_BAD_ADDR;
    if (mtype == TYPE_INVALID) return ST_BAD_TYPE;
    if (last < start) return ST_BAD_RANGE;
    for (k = 0; k < NUM_ENTRIES; k++) begin
      if (region_table[k].mtype != TYPE_INVALID) begin
        e_last = region_table[k].start + region_table[k].size - 32'd1;
        if (start < region_table[k].start || start > e_last) begin
          status = ST_BAD_ADDR;
        end else if (last > e_last) begin
          status = ST_BAD_RANGE;
        end else if (mtype == TYPE_ANY || mtype == region_table[k].mtype) begin
          return ST_OK;
        end else begin
          status = ST_BAD_TYPE;
        end
      end
    end
    return status;
  endfunction

  // Applies one request to the local table and returns its result.
  function automatic region_result_t predict_region_op(input region_req_t req);
    region_result_t res;
    res = '0;
    case (req.opcode)
      OP_VALIDATE: begin
        res.status = range_lookup_status(req.mtype, req.start, req.size);
      end
      OP_SET: begin
        if (req.index >= NUM_ENTRIES) begin
          res.status = ST_BAD_RANGE;
        end else if (req.mtype != TYPE_RAM && req.mtype != TYPE_EEPROM) begin
          res.status = ST_BAD_TYPE;
        end else if (req.wsize == WSIZE_INVALID) begin
          res.status = ST_BAD_WSIZE;
        end else if (req.attr == ATTR_INVALID) begin
          res.status = ST_BAD_ATTR;
        end else begin
          region_table[req.index].mtype = req.mtype;
          region_table[req.index].start = req.start;
          region_table[req.index].size  = req.size;
          region_table[req.index].wsize = req.wsize;
          region_table[req.index].attr  = req.attr;
        end
      end
      OP_GET: begin
        if (req.index >= NUM_ENTRIES) begin
          res.status = ST_BAD_RANGE;
        end else begin
          res.entry = region_table[req.index];
        end
      end
      default: begin
        // The unused opcode leaves everything alone and reports success.
      end
    endcase
    return res;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Sends one transaction and records its predicted result on acceptance.
  task automatic send_request(input region_req_t req);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode      <= req.opcode;
    in_range_index <= req.index;
    in_mem_type    <= req.mtype;
    in_start_addr  <= req.start;
    in_range_size  <= req.size;
    in_word_size   <= req.wsize;
    in_attributes  <= req.attr;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_region_op(req));
  endtask

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    region_result_t got;
    region_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status       = out_status;
      got.entry.mtype  = out_type_out;
      got.entry.start  = out_start_out;
      got.entry.size   = out_size_out;
      got.entry.wsize  = out_word_size_out;
      got.entry.attr   = out_attributes_out;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d", got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.entry.mtype !== want.entry.mtype ||
            got.entry.start !== want.entry.start || got.entry.size !== want.entry.size ||
            got.entry.wsize !== want.entry.wsize || got.entry.attr !== want.entry.attr) begin
          flag_error($sformatf({"mismatch: expected st %0d ty %0d start %h size %h ws %0d ",
                                "at %0d, got st %0d ty %0d start %h size %h ws %0d at %0d"},
                               want.status, want.entry.mtype, want.entry.start,
                               want.entry.size, want.entry.wsize, want.entry.attr,
                               got.status, got.entry.mtype, got.entry.start,
                               got.entry.size, got.entry.wsize, got.entry.attr));
        end
      end
    end
  end

  // Random traffic: mostly well-formed sets and gets and validates aimed at
  // stored regions, the rest fully random noise.
  function automatic region_req_t random_traffic_request();
    region_req_t req;
    mrtc_entry_t region;
    logic [7:0]  live [$];
    logic [31:0] offset;
    logic [31:0] span;
    int          roll;
    req.opcode = 2'($urandom);
    req.index  = 8'($urandom);
    req.mtype  = 2'($urandom);
    req.start  = $urandom;
    req.size   = $urandom;
    req.wsize  = 2'($urandom);
    req.attr   = 2'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 20) return req;
    if (roll < 38) begin
      req.opcode = OP_SET;
      req.index  = 8'($urandom_range(0, NUM_ENTRIES - 1));
      req.mtype  = 2'($urandom_range(TYPE_RAM, TYPE_EEPROM));
      req.wsize  = 2'($urandom_range(WSIZE_BYTE, WSIZE_DWORD));
      req.attr   = 2'($urandom_range(ATTR_READ, ATTR_RW));
      if ($urandom_range(0, 31) == 0) begin
        // A region that covers the whole address space.
        req.start = '0;
        req.size  = '0;
      end else if ($urandom_range(0, 3) != 0) begin
        req.size = $urandom_range(1, 32'h1_0000);
      end
      return req;
    end
    if (roll < 50) begin
      req.opcode = OP_GET;
      req.index  = 8'($urandom_range(0, NUM_ENTRIES - 1));
      return req;
    end
    req.opcode = OP_VALIDATE;
    req.mtype  = ($urandom_range(0, 15) == 0) ? TYPE_INVALID :
                 2'($urandom_range(TYPE_RAM, TYPE_ANY));
    foreach (region_table[k]) begin
      if (region_table[k].mtype != TYPE_INVALID) live.push_back(8'(k));
    end
    if (live.size() == 0) begin
      req.size = $urandom_range(0, 256);
      return req;
    end
    region = region_table[live[$urandom_range(0, live.size() - 1)]];
    case ($urandom_range(0, 7))
      0:       offset = -$urandom_range(1, 16);
      1:       offset = region.size + $urandom_range(0, 16);
      default: offset = (region.size == 0) ? $urandom : $urandom_range(0, region.size - 1);
    endcase
    req.start = region.start + offset;
    span      = region.size - offset;
    case ($urandom_range(0, 3))
      0, 1:    req.size = $urandom_range(1, span);
      2:       req.size = span + $urandom_range(1, 16);
      default: req.size = $urandom_range(0, 8);
    endcase
    return req;
  endfunction

  // Lookups and reads against the table right after reset.
  task automatic test_empty_table();
    send_request(make_req(OP_VALIDATE, '0, TYPE_ANY, '0, '0, WSIZE_BYTE, ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_RAM, '1, '1, WSIZE_BYTE, ATTR_READ));
    send_request(make_req(OP_GET, '0, TYPE_INVALID, '0, '0, WSIZE_BYTE, ATTR_INVALID));
    send_request(make_req(OP_GET, '1, TYPE_INVALID, '0, '0, WSIZE_BYTE, ATTR_INVALID));
  endtask

  // Operand checks of set, in order of precedence.
  task automatic test_set_operand_checks();
    send_request(make_req(OP_SET, '1, TYPE_INVALID, '1, '1, WSIZE_INVALID, ATTR_INVALID));
    send_request(make_req(OP_SET, 8'(NUM_ENTRIES), TYPE_RAM, 32'h100, 32'h10, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_SET, '0, TYPE_ANY, 32'h100, 32'h10, WSIZE_BYTE, ATTR_READ));
    send_request(make_req(OP_SET, '0, TYPE_INVALID, 32'h100, 32'h10, WSIZE_BYTE, ATTR_READ));
    send_request(make_req(OP_SET, '0, TYPE_RAM, 32'h100, 32'h10, WSIZE_INVALID,
                          ATTR_INVALID));
    send_request(make_req(OP_SET, 8'd1, TYPE_EEPROM, 32'h100, 32'h10, WSIZE_DWORD,
                          ATTR_INVALID));
  endtask

  // Stores a few regions and reads them back.
  task automatic test_set_and_get();
    send_request(make_req(OP_SET, '0, TYPE_RAM, 32'h1000, 32'h100, WSIZE_BYTE, ATTR_READ));
    send_request(make_req(OP_SET, 8'(NUM_ENTRIES - 1), TYPE_EEPROM, 32'hFFFF_FF00, 32'h100,
                          WSIZE_DWORD, ATTR_RW));
    send_request(make_req(OP_SET, 8'd3, TYPE_RAM, 32'h8000_0000, 32'h10, WSIZE_WORD,
                          ATTR_WRITE));
    send_request(make_req(OP_GET, '0, TYPE_INVALID, '0, '0, WSIZE_BYTE, ATTR_INVALID));
    send_request(make_req(OP_GET, 8'(NUM_ENTRIES - 1), TYPE_INVALID, '0, '0, WSIZE_BYTE,
                          ATTR_INVALID));
    send_request(make_req(OP_GET, 8'd3, TYPE_INVALID, '0, '0, WSIZE_BYTE, ATTR_INVALID));
  endtask

  // Range lookups: hits, type mismatch, overrun, wrap, zero size, bad type.
  task automatic test_validate_cases();
    send_request(make_req(OP_VALIDATE, '0, TYPE_RAM, 32'h1000, 32'h100, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_EEPROM, 32'hFFFF_FFF0, 32'h10, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_EEPROM, 32'h1000, 32'h10, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_RAM, 32'h8000_0008, 32'h10, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_ANY, 32'h8000_0000, 32'h10, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_INVALID, 32'h1000, 32'h10, WSIZE_BYTE,
                          ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_RAM, 32'h5, '0, WSIZE_BYTE, ATTR_READ));
    send_request(make_req(OP_VALIDATE, '0, TYPE_ANY, 32'hFFFF_FFFF, 32'h2, WSIZE_BYTE,
                          ATTR_READ));
  endtask

  task automatic test_unused_opcode();
    send_request(make_req(OP_UNUSED, '1, TYPE_ANY, '1, '1, WSIZE_INVALID, ATTR_RW));
  endtask

  // Random traffic with idling on both channels.
  task automatic test_random_traffic(input int count);
    idle_on <= 1'b1;
    repeat (count) send_request(random_traffic_request());
  endtask

  // Random traffic at full rate on both channels.
  task automatic test_streaming_traffic(input int count);
    idle_on <= 1'b0;
    repeat (count) send_request(random_traffic_request());
  endtask

  initial begin
    foreach (region_table[k]) region_table[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_set_operand_checks();
    test_set_and_get();
    test_validate_cases();
    test_unused_opcode();
    test_random_traffic(1000);
    test_streaming_traffic(500);
    test_random_traffic(500);

    // Let every outstanding result drain, then watch for stray ones.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("memory_range_table_checker verification clean");
    end else begin
      $display("memory_range_table_checker verification failed");
    end
    $finish;
  end

endmodule
